FILE: rtl/isu_pkg.sv
// Shared types and constants for the insertion sorter.
// Holds the transfer structs, the cell link struct and the store depth.
// No dependencies.
`default_nettype none

package isu_pkg;

	localparam int DEPTH = 64;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               final_res;
		logic               overflow;
	} out_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic               valid;
		logic               gt;
		logic signed [31:0] value;
	} link_t;

	// chain-wide command: insert or shift
	typedef struct packed {
		logic ins;
		logic shift;
	} ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/isu_cell.sv
// One cell of the insertion chain: holds one sorted entry and its valid bit.
// Inserts by taking the new value or its lower neighbor's entry; drains by
// taking its upper neighbor's entry. Depends on isu_pkg.
`default_nettype none

module isu_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire isu_pkg::ctrl_t            ctrl,
	input  wire logic signed [31:0]        new_value,
	input  wire isu_pkg::link_t            lower,
	input  wire isu_pkg::link_t            upper,
	output isu_pkg::link_t                 own
);
	import isu_pkg::*;

	logic               valid_q;
	logic signed [31:0] value_q;
	logic               gt;

	// empty cells count as greater, so a value above all entries lands in the first free slot
	assign gt = !valid_q || (value_q > new_value);

	assign own.valid = valid_q;
	assign own.gt    = gt;
	assign own.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= upper.valid;
		end else if (ctrl.ins && gt) begin
			valid_q <= valid_q | lower.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= upper.value;
		end else if (ctrl.ins && gt) begin
			value_q <= lower.gt ? lower.value : new_value;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/insertion_sorter_unit.sv
// Top level of the insertion sorter: a chain of DEPTH sorting cells plus
// the drain control. Depends on isu_pkg and isu_cell.
//
// Usage:
//   Input: an item (value, last) transfers at a rising edge with start high
//   and busy low. Each value is placed into the sorted chain in the same
//   cycle it transfers; all cells compare against it in parallel, so while
//   a list is being filled one value is taken every cycle.
//   A value that arrives while all DEPTH cells hold entries is dropped and
//   the list is marked as overflowed.
//   An item with last high closes the list. From the next cycle on, the
//   chain drains toward cell 0: one result per cycle, ascending, strobed by
//   result_valid for exactly one cycle. final_res marks the largest entry;
//   overflow is set on every result of a list that dropped values.
//   busy is high while the stored entries drain, so no new item is taken
//   until the largest entry of the list has been shown.
//   The receiver cannot stall; results must be taken when strobed.
//   Reset clears all valid bits, the drain state and the overflow mark;
//   the store is empty afterward and ready for a new list.
`default_nettype none

module insertion_sorter_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire isu_pkg::in_t   item,
	output logic                result_valid,
	output isu_pkg::out_t       result
);
	import isu_pkg::*;

	link_t cells   [DEPTH];
	link_t lowers  [DEPTH];
	link_t uppers  [DEPTH];
	ctrl_t ctrl;
	logic  drain_q;
	logic  drop_q;
	logic  take;
	logic  full;
	logic  last_out;

	assign busy     = drain_q;
	assign take     = start && !drain_q;
	assign full     = cells[DEPTH-1].valid;
	assign last_out = !cells[1].valid;

	assign ctrl.ins   = take && !full;
	assign ctrl.shift = drain_q;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_chain
			if (i == 0) begin : g_first
				assign lowers[i] = '{valid: 1'b1, gt: 1'b0, value: '0};
			end else begin : g_rest
				assign lowers[i] = cells[i-1];
			end
			if (i == DEPTH - 1) begin : g_top
				assign uppers[i] = '{valid: 1'b0, gt: 1'b1, value: '0};
			end else begin : g_mid
				assign uppers[i] = cells[i+1];
			end
			isu_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.new_value (item.value),
				.lower     (lowers[i]),
				.upper     (uppers[i]),
				.own       (cells[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (drain_q) begin
			if (last_out) begin
				drain_q <= 1'b0;
				drop_q  <= 1'b0;
			end
		end else if (take) begin
			if (full) begin
				drop_q <= 1'b1;
			end
			if (item.last) begin
				drain_q <= 1'b1;
			end
		end
	end

	assign result_valid        = drain_q;
	assign result.sorted_value = cells[0].value;
	assign result.final_res    = last_out;
	assign result.overflow     = drop_q;

endmodule

`default_nettype wire
